### rtl/rtu_frame_receiver_crc_check_unit_macros.svh
// assertion macros used by the checker file of the rtu frame receiver
// no dependencies; include by bare file name
`ifndef RTU_FRAME_RECEIVER_CRC_CHECK_UNIT_MACROS_SVH
`define RTU_FRAME_RECEIVER_CRC_CHECK_UNIT_MACROS_SVH

// property checked on rising clock edges, suspended while reset is high
`define RFRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define RFRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rfrc_pkg.sv
// shared types, codes, constants and the crc-16 byte update of the rtu frame receiver
// no dependencies
package rfrc_pkg;

  // receive buffer size in bytes (8 to 256)
  localparam int unsigned BUFFER_BYTES = 256;
  localparam logic [8:0]  BUFFER_LIMIT = 9'(BUFFER_BYTES);
  localparam logic [7:0]  OVERFLOW_LENGTH = 8'(BUFFER_BYTES - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] SILENCE_RESET = 16'd4;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd4;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_TICKS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_FRAME_BYTES = 1'b1;

  // input item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_CRC_ERROR = 2'd1,
    STATUS_TOO_SHORT = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_length;
    logic [7:0] slave_address;
    logic [7:0] function_code;
  } result_t;

  // reflected crc-16 update over one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/rfrc_frame_core.sv
// frame state, configuration registers and per-item framing/crc decision
// depends on rfrc_pkg
module rfrc_frame_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic [rfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept,
  input  logic                             command,
  input  logic [7:0]                       rx_byte,
  output logic                             push,
  output rfrc_pkg::result_t                result
);

  logic [15:0] silence_ticks;
  logic [7:0]  min_frame_bytes;

  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] idle_count, idle_count_next;
  logic [15:0] crc_before_tail, crc_before_tail_next;
  logic [15:0] tail_bytes, tail_bytes_next;
  logic [7:0]  address_byte, address_byte_next;
  logic [7:0]  function_byte, function_byte_next;

  logic [15:0] idle_inc;
  logic [15:0] tail_crc;
  logic        emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_ticks   <= rfrc_pkg::SILENCE_RESET;
      min_frame_bytes <= rfrc_pkg::MIN_LEN_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rfrc_pkg::REG_SILENCE_TICKS:   silence_ticks   <= cfg_data;
        rfrc_pkg::REG_MIN_FRAME_BYTES: min_frame_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign idle_inc = (idle_count == rfrc_pkg::IDLE_MAX) ? idle_count : idle_count + 16'd1;
  assign tail_crc = {tail_bytes[7:0], tail_bytes[15:8]};

  always_comb begin
    byte_count_next      = byte_count;
    idle_count_next      = idle_count;
    crc_before_tail_next = crc_before_tail;
    tail_bytes_next      = tail_bytes;
    address_byte_next    = address_byte;
    function_byte_next   = function_byte;
    emit                 = 1'b0;
    result.status        = rfrc_pkg::STATUS_VALID;
    result.frame_length  = byte_count;
    result.slave_address = address_byte;
    result.function_code = function_byte;

    if (accept) begin
      if (command == rfrc_pkg::CMD_BYTE) begin
        if (({1'b0, byte_count} + 9'd1) >= rfrc_pkg::BUFFER_LIMIT) begin
          emit          = 1'b1;
          result.status = rfrc_pkg::STATUS_OVERFLOW;
        end else begin
          if (byte_count >= 8'd2) begin
            crc_before_tail_next = rfrc_pkg::crc_feed(crc_before_tail, tail_bytes[15:8]);
          end
          tail_bytes_next = {tail_bytes[7:0], rx_byte};
          if (byte_count == 8'd0) begin
            address_byte_next = rx_byte;
          end else if (byte_count == 8'd1) begin
            function_byte_next = rx_byte;
          end
          byte_count_next = byte_count + 8'd1;
          idle_count_next = 16'd0;
        end
      end else if (byte_count != 8'd0) begin
        idle_count_next = idle_inc;
        if (idle_inc >= silence_ticks) begin
          emit = 1'b1;
          if (byte_count < min_frame_bytes || byte_count < 8'd2) begin
            result.status = rfrc_pkg::STATUS_TOO_SHORT;
          end else if (tail_crc == crc_before_tail) begin
            result.status = rfrc_pkg::STATUS_VALID;
          end else begin
            result.status = rfrc_pkg::STATUS_CRC_ERROR;
          end
        end
      end
    end

    // any reported frame returns the framer to its empty state
    if (emit) begin
      byte_count_next      = 8'd0;
      idle_count_next      = 16'd0;
      crc_before_tail_next = rfrc_pkg::CRC_INIT;
      tail_bytes_next      = 16'd0;
      address_byte_next    = 8'd0;
      function_byte_next   = 8'd0;
    end
  end

  assign push = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= 8'd0;
      idle_count      <= 16'd0;
      crc_before_tail <= rfrc_pkg::CRC_INIT;
      tail_bytes      <= 16'd0;
      address_byte    <= 8'd0;
      function_byte   <= 8'd0;
    end else begin
      byte_count      <= byte_count_next;
      idle_count      <= idle_count_next;
      crc_before_tail <= crc_before_tail_next;
      tail_bytes      <= tail_bytes_next;
      address_byte    <= address_byte_next;
      function_byte   <= function_byte_next;
    end
  end

endmodule

### rtl/rfrc_out_queue.sv
// two-entry result queue between the framer and the output channel
// depends on rfrc_pkg
module rfrc_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfrc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output rfrc_pkg::result_t out_data
);

  rfrc_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/rtu_frame_receiver_crc_check_unit.sv
// top level of the rtu frame receiver with crc-16 check
// depends on rfrc_pkg, rfrc_frame_core and rfrc_out_queue
//
// Modbus RTU receive framer. Each input item is either a received byte
// (command 0) or one time tick (command 1). Bytes are counted and a reflected
// CRC-16 (init FFFF, poly A001) runs over all bytes but the last two, which are
// held as the candidate crc, low byte first on the wire. Once silence_ticks
// ticks pass after the last byte (a value of 0 behaves as 1), one result item
// reports the frame: status 0 valid, 1 crc error, 2 too short (below
// min_frame_bytes or under two bytes), with length, address and function
// bytes (0 where the frame never reached them). A byte that would fill the
// BUFFER_BYTES buffer drops the frame and itself and reports status 3 with the
// length held so far. Ticks while no frame is open give nothing. Each item
// is handled as it is accepted: the frame registers update at the accepting edge
// and any result lands in a two-entry output queue, visible on out_valid right
// after that edge, so a new item is taken every cycle while in_stall is low;
// in_stall is high whenever both queue entries are held, which is reached only
// while out_stall holds the output. Configuration writes (silence_ticks index 0,
// min_frame_bytes index 1, reset values 4 and 4) belong in idle time between
// frames.
module rtu_frame_receiver_crc_check_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write_enable,
  input  logic [rfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [7:0]                       rx_byte,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [7:0]                       frame_length,
  output logic [7:0]                       slave_address,
  output logic [7:0]                       function_code
);

  logic              accept;
  logic              push;
  logic              queue_full;
  rfrc_pkg::result_t core_result;
  rfrc_pkg::result_t head;

  // stall comes from queue occupancy alone, so it never waits on in_valid
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  rfrc_frame_core u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .accept           (accept),
    .command          (command),
    .rx_byte          (rx_byte),
    .push             (push),
    .result           (core_result)
  );

  rfrc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (core_result),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign status        = head.status;
  assign frame_length  = head.frame_length;
  assign slave_address = head.slave_address;
  assign function_code = head.function_code;

endmodule

### rtl/rfrc_checker.sv
// port-level checker for the rtu frame receiver, bound to the top level
// depends on rfrc_pkg and rtu_frame_receiver_crc_check_unit_macros.svh
`include "rtu_frame_receiver_crc_check_unit_macros.svh"

module rfrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] frame_length,
  input logic [7:0] slave_address,
  input logic [7:0] function_code
);

  logic        in_accept;
  logic [25:0] out_item;

  assign in_accept = in_valid && !in_stall;
  assign out_item  = {status, frame_length, slave_address, function_code};

  `RFRC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled item dropped or changed")
  `RFRC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result shown right after reset")
  `RFRC_ASSERT(a_result_cause, clk, rst, out_valid && !$past(out_valid) && !$past(rst) |-> $past(in_accept), "result item without an accepted input item")
  `RFRC_ASSERT(a_overflow_length, clk, rst, out_valid && status == rfrc_pkg::STATUS_OVERFLOW |-> frame_length == rfrc_pkg::OVERFLOW_LENGTH, "overflow with wrong frame length")
  `RFRC_ASSERT(a_valid_length, clk, rst, out_valid && status == rfrc_pkg::STATUS_VALID |-> frame_length >= 8'd2, "valid frame shorter than a crc")

endmodule

bind rtu_frame_receiver_crc_check_unit rfrc_checker u_rfrc_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for rtu_frame_receiver_crc_check_unit: directed and random
// byte/tick items against an in-bench frame predictor; depends on rfrc_pkg and the rtl
module testbench;

  // one pending input item; hold marks a point where the sender waits for all reports
  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         hold;
  } rx_item_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_write_enable = 1'b0;
  logic [rfrc_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [rfrc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 command = rfrc_pkg::CMD_TICK;
  logic [7:0]                           rx_byte = 8'h00;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [1:0]                           status;
  logic [7:0]                           frame_length;
  logic [7:0]                           slave_address;
  logic [7:0]                           function_code;

  rtu_frame_receiver_crc_check_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .frame_length     (frame_length),
    .slave_address    (slave_address),
    .function_code    (function_code)
  );

  // stimulus and expected reports
  rx_item_t           rx_items_due[$];
  rfrc_pkg::result_t  reports_due[$];
  int                 fail_count = 0;

  // idle and stall rates in percent, set per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor copy of the registers and the frame state
  logic [15:0] silence_cfg = rfrc_pkg::SILENCE_RESET;
  logic [7:0]  min_len_cfg = rfrc_pkg::MIN_LEN_RESET;
  logic [7:0]  rx_count = 8'd0;
  logic [15:0] idle_run = 16'd0;
  logic [15:0] crc_acc = rfrc_pkg::CRC_INIT;
  logic [15:0] tail = 16'd0;
  logic [7:0]  addr_seen = 8'd0;
  logic [7:0]  func_seen = 8'd0;

  // clock, 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // reflected crc-16, one bit at a time: feedback is crc lsb xor data bit
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) c = c ^ rfrc_pkg::CRC_POLY;
    end
    return c;
  endfunction

  // close the frame: queue its report and return to the empty frame state
  task report_frame(input rfrc_pkg::status_t st);
    rfrc_pkg::result_t r;
    r.status = st;
    r.frame_length = rx_count;
    r.slave_address = addr_seen;
    r.function_code = func_seen;
    reports_due.push_back(r);
    rx_count = 8'd0;
    idle_run = 16'd0;
    crc_acc = rfrc_pkg::CRC_INIT;
    tail = 16'd0;
    addr_seen = 8'd0;
    func_seen = 8'd0;
  endtask

  // frame state update for one accepted item
  task predict_frame_report(input logic cmd, input logic [7:0] b);
    logic [15:0] wire_crc;
    if (cmd == rfrc_pkg::CMD_BYTE) begin
      // a byte that would fill the buffer throws away the frame and itself
      if (int'(rx_count) + 1 >= rfrc_pkg::BUFFER_BYTES) begin
        report_frame(rfrc_pkg::STATUS_OVERFLOW);
        return;
      end
      // the two newest bytes stay out of the crc as the candidate tail
      if (rx_count >= 8'd2) crc_acc = crc16_step(crc_acc, tail[15:8]);
      tail = {tail[7:0], b};
      if (rx_count == 8'd0) addr_seen = b;
      else if (rx_count == 8'd1) func_seen = b;
      rx_count = rx_count + 8'd1;
      idle_run = 16'd0;
    end else begin
      // ticks only count while a frame is open
      if (rx_count == 8'd0) return;
      if (idle_run != rfrc_pkg::IDLE_MAX) idle_run = idle_run + 16'd1;
      if (idle_run < silence_cfg) return;
      if (rx_count < min_len_cfg || rx_count < 8'd2) begin
        report_frame(rfrc_pkg::STATUS_TOO_SHORT);
      end else begin
        // crc travels low byte first
        wire_crc = {tail[7:0], tail[15:8]};
        report_frame(wire_crc == crc_acc ? rfrc_pkg::STATUS_VALID : rfrc_pkg::STATUS_CRC_ERROR);
      end
    end
  endtask

  // driver: predicts at acceptance, then offers the next item unless idling
  always @(posedge clk) begin : drive_items
    rx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_frame_report(command, rx_byte);
      if (!(in_valid && in_stall)) begin
        // a hold marker releases once every report has come back
        if (rx_items_due.size() != 0 && rx_items_due[0].hold && reports_due.size() == 0) begin
          void'(rx_items_due.pop_front());
        end
        if (rx_items_due.size() != 0 && !rx_items_due[0].hold &&
            $urandom_range(99) >= send_idle_pct) begin
          it = rx_items_due.pop_front();
          in_valid <= 1'b1;
          command <= it.cmd;
          rx_byte <= it.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every accepted report must match the oldest expected one
  always @(posedge clk) begin : check_reports
    rfrc_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("report with none expected: status %0d length %0d", status, frame_length);
        fail_count++;
      end else begin
        want = reports_due.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length);
          fail_count++;
        end
        if (slave_address !== want.slave_address) begin
          $error("slave_address: expected %0d, got %0d", want.slave_address, slave_address);
          fail_count++;
        end
        if (function_code !== want.function_code) begin
          $error("function_code: expected %0d, got %0d", want.function_code, function_code);
          fail_count++;
        end
      end
    end
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  task add_byte(input logic [7:0] b);
    rx_item_t it;
    it.cmd = rfrc_pkg::CMD_BYTE;
    it.data = b;
    it.hold = 1'b0;
    rx_items_due.push_back(it);
  endtask

  // ticks carry a random data byte, which the block ignores
  task add_ticks(input int n);
    rx_item_t it;
    for (int i = 0; i < n; i++) begin
      it.cmd = rfrc_pkg::CMD_TICK;
      it.data = 8'($urandom_range(255));
      it.hold = 1'b0;
      rx_items_due.push_back(it);
    end
  endtask

  task add_hold();
    rx_item_t it;
    it.cmd = rfrc_pkg::CMD_TICK;
    it.data = 8'h00;
    it.hold = 1'b1;
    rx_items_due.push_back(it);
  endtask

  // body plus its crc (low byte first); optional bit flip and short tick gaps between bytes
  task add_frame(input logic [7:0] body[$], input bit corrupt, input bit gaps);
    logic [7:0]  wire_bytes[$];
    logic [15:0] crc;
    int          sil;
    int          pos;
    crc = rfrc_pkg::CRC_INIT;
    sil = (silence_cfg == 16'd0) ? 1 : int'(silence_cfg);
    wire_bytes = body;
    foreach (body[i]) crc = crc16_step(crc, body[i]);
    wire_bytes.push_back(crc[7:0]);
    wire_bytes.push_back(crc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(wire_bytes.size() - 1);
      wire_bytes[pos] = wire_bytes[pos] ^ 8'(1 << $urandom_range(7));
    end
    foreach (wire_bytes[i]) begin
      // gaps stay below the silence time so the frame keeps going
      if (gaps && i > 0 && sil > 1 && $urandom_range(3) == 0)
        add_ticks($urandom_range(1, (sil - 1 > 6) ? 6 : sil - 1));
      add_byte(wire_bytes[i]);
    end
  endtask

  // mostly well-formed frames with random content, mixed with noise and broken frames
  task add_random_traffic(input int target);
    logic [7:0] body[$];
    int         start_size;
    int         made;
    int         pick;
    int         body_len;
    int         sil;
    made = 0;
    while (made < target) begin
      start_size = rx_items_due.size();
      sil = (silence_cfg == 16'd0) ? 1 : int'(silence_cfg);
      pick = $urandom_range(99);
      body.delete();
      body_len = ($urandom_range(19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      for (int i = 0; i < body_len; i++) body.push_back(8'($urandom_range(255)));
      if (pick < 55) begin
        // complete frame, now and then with a damaged bit
        add_frame(body, $urandom_range(5) == 0, 1'b1);
        add_ticks(sil + $urandom_range(0, 2));
      end else if (pick < 68) begin
        // frame followed by too short a pause: runs into the next one
        add_frame(body, 1'b0, 1'b1);
        if (sil > 1) add_ticks($urandom_range(1, (sil - 1 > 6) ? 6 : sil - 1));
      end else if (pick < 84) begin
        // raw bytes with no crc at all
        for (int i = 0; i < $urandom_range(1, 6); i++) add_byte(8'($urandom_range(255)));
        add_ticks(sil + $urandom_range(0, 1));
      end else if (pick < 99) begin
        // stray ticks, mostly with nothing open
        add_ticks($urandom_range(1, 5));
      end else begin
        // runaway frame that hits the buffer limit
        for (int i = 0; i < rfrc_pkg::BUFFER_BYTES + $urandom_range(0, 3); i++)
          add_byte(8'($urandom_range(255)));
        add_ticks(sil);
      end
      made += rx_items_due.size() - start_size;
    end
  endtask

  // wait until the block is drained; close any frame left open, then a short quiet spell
  task drain_block();
    bit open_frame;
    open_frame = 1'b1;
    while (open_frame) begin
      do @(negedge clk);
      while (rx_items_due.size() != 0 || in_valid || reports_due.size() != 0);
      open_frame = (rx_count != 8'd0);
      if (open_frame) add_ticks((silence_cfg == 16'd0) ? 1 : int'(silence_cfg));
    end
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input logic [rfrc_pkg::CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    if (idx == rfrc_pkg::REG_SILENCE_TICKS) silence_cfg = value;
    else min_len_cfg = value[7:0];
  endtask

  task start_phase(input logic [15:0] sil, input logic [7:0] min_len,
                   input int idle_pct, input int stall_pct);
    write_reg(rfrc_pkg::REG_SILENCE_TICKS, sil);
    write_reg(rfrc_pkg::REG_MIN_FRAME_BYTES, 16'(min_len));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // main sequence
  initial begin : run_phases
    logic [7:0] body[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset settings (silence 4, min length 4)
    add_ticks(1);                      // tick with no frame open
    add_byte(8'h01);                   // one-byte frame, function code stays 0
    add_ticks(4);
    add_byte(8'hFF);                   // two bytes: below the minimum length
    add_byte(8'h80);
    add_ticks(4);
    body = '{8'hFF, 8'h00};            // good crc, length 4
    add_frame(body, 1'b0, 1'b0);
    add_ticks(3);                      // one tick short of silence, frame still open
    add_ticks(1);                      // the fourth tick ends it
    body = '{8'h00, 8'hFF};            // damaged crc
    add_frame(body, 1'b1, 1'b0);
    add_ticks(4);
    add_random_traffic(150);
    drain_block();

    // shortest silence and length, sender idling
    start_phase(16'd1, 8'd1, 46, 0);
    add_random_traffic(80);
    add_hold();
    add_random_traffic(80);
    drain_block();

    // zero settings behave as the smallest ones, receiver stalling
    start_phase(16'd0, 8'd0, 0, 46);
    add_random_traffic(150);
    drain_block();

    // largest minimum length: full-length frame, buffer overflow, then a three-byte short frame
    start_phase(16'd20, 8'd255, 22, 22);
    body.delete();
    for (int i = 0; i < rfrc_pkg::BUFFER_BYTES - 3; i++) body.push_back(8'($urandom_range(255)));
    add_frame(body, 1'b0, 1'b0);
    add_ticks(20);
    for (int i = 0; i < rfrc_pkg::BUFFER_BYTES; i++) add_byte(8'($urandom_range(255)));
    for (int i = 0; i < 3; i++) add_byte(8'($urandom_range(255)));
    drain_block();

    // mid settings, both sides idling
    start_phase(16'd3, 8'd8, 22, 22);
    add_random_traffic(150);
    drain_block();

    // no idling, with the sender waiting out every report now and then
    start_phase(16'd7, 8'd4, 0, 0);
    for (int k = 0; k < 3; k++) begin
      add_random_traffic(60);
      add_hold();
    end
    add_random_traffic(60);
    drain_block();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

### rtu_frame_receiver_crc_check_unit.f
+incdir+rtl
rtl/rfrc_pkg.sv
rtl/rfrc_frame_core.sv
rtl/rfrc_out_queue.sv
rtl/rtu_frame_receiver_crc_check_unit.sv
rtl/rfrc_checker.sv
sim/testbench.sv
